[rtl/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: shared package
// Widths, character codes, the queued transaction type and the back-end
// state type used by every file of the converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

   // Width of the signed input value.
   localparam int VALUE_BITS = 32;

   // Decimal digits needed for any magnitude of VALUE_BITS bits.
   // VALUE_BITS * log10(2) is approximated by VALUE_BITS * 1233 / 4096.
   localparam int DIGIT_COUNT = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int BCD_BITS    = DIGIT_COUNT * 4;

   // The binary-to-BCD conversion consumes four magnitude bits per cycle.
   localparam int BITS_PER_STEP = 4;
   localparam int STEP_COUNT    = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int PAD_BITS      = STEP_COUNT * BITS_PER_STEP;
   localparam int STEP_W        = $clog2(STEP_COUNT + 1);
   localparam int IDX_W         = $clog2(DIGIT_COUNT);

   // Depth of the queue between front and back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CHAR_BITS = 7;
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_BITS-1:0] ASCII_NINE  = 7'h39;
   localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 7'h2D;

   // A classified transaction: sign flag and unsigned magnitude.
   typedef struct packed {
      logic                  neg;
      logic [VALUE_BITS-1:0] mag;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CONVERT,
      BK_LOCATE,
      BK_SIGN,
      BK_DIGITS
   } back_state_type;

endpackage

[rtl/sitda_front.sv]
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: front end
// Accepts a value, splits it into sign and unsigned magnitude, and holds the
// result in a register until the queue takes it.
// ----------------------------------------------------------------------------
module sitda_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [sitda_pkg::VALUE_BITS-1:0] req_value,
   output logic                                    push_valid,
   input  logic                                    push_ready,
   output sitda_pkg::item_type                     push_item
);
   import sitda_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   item_type              item_ff;
   item_type              item_in;
   logic [VALUE_BITS-1:0] raw;
   logic                  accept;

   // The magnitude is formed unsigned, so the most negative value is exact.
   assign raw          = VALUE_BITS'(req_value);
   assign item_in.neg  = raw[VALUE_BITS-1];
   assign item_in.mag  = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

   assign req_ready  = !valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign valid_in   = accept || (valid_ff && !push_ready);
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

[rtl/sitda_queue.sv]
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: transaction queue
// A short register queue between front and back end.
// ----------------------------------------------------------------------------
module sitda_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  sitda_pkg::item_type push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output sitda_pkg::item_type pop_item
);
   import sitda_pkg::*;

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/sitda_back.sv]
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: back end
// Converts a magnitude to BCD by shift-and-add-three, four bits a cycle,
// finds the leading digit and sends the characters through an output register.
// ----------------------------------------------------------------------------
module sitda_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   pop_valid,
   output logic                                   pop_ready,
   input  sitda_pkg::item_type                    pop_item,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sitda_pkg::CHAR_BITS-1:0]        rsp_ascii_char,
   output logic                                   rsp_last_char
);
   import sitda_pkg::*;

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [BCD_BITS-1:0]   bcd_ff;
   logic [BCD_BITS-1:0]   bcd_in;
   logic [PAD_BITS-1:0]   bin_ff;
   logic [PAD_BITS-1:0]   bin_in;
   logic [STEP_W-1:0]     step_ff;
   logic [STEP_W-1:0]     step_in;
   logic                  neg_ff;
   logic                  neg_in;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      idx_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CHAR_BITS-1:0]  char_ff;
   logic [CHAR_BITS-1:0]  char_in;
   logic                  last_ff;
   logic                  last_in;
   logic                  out_load;
   logic                  out_free;
   logic [BCD_BITS-1:0]   dab_bcd;
   logic [PAD_BITS-1:0]   dab_bin;
   logic [IDX_W-1:0]      lead_idx;
   logic [3:0]            cur_digit;

   // Four shift-and-add-three steps; within a step every digit is independent.
   always_comb begin
      dab_bcd = bcd_ff;
      dab_bin = bin_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < DIGIT_COUNT; d++) begin
            if (dab_bcd[d*4 +: 4] >= 4'd5) begin
               dab_bcd[d*4 +: 4] = dab_bcd[d*4 +: 4] + 4'd3;
            end
         end
         {dab_bcd, dab_bin} = {dab_bcd[BCD_BITS-2:0], dab_bin, 1'b0};
      end
   end

   // Highest non-zero digit; zero falls back to the lowest digit.
   always_comb begin
      lead_idx = '0;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            lead_idx = IDX_W'(d);
         end
      end
   end

   assign cur_digit = bcd_ff[{idx_ff, 2'b00} +: 4];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      bcd_in    = bcd_ff;
      bin_in    = bin_ff;
      step_in   = step_ff;
      neg_in    = neg_ff;
      idx_in    = idx_ff;
      pop_ready = 1'b0;
      out_load  = 1'b0;
      char_in   = char_ff;
      last_in   = last_ff;
      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               bcd_in   = '0;
               bin_in   = PAD_BITS'(pop_item.mag);
               neg_in   = pop_item.neg;
               step_in  = '0;
               state_in = BK_CONVERT;
            end
         end
         BK_CONVERT: begin
            bcd_in  = dab_bcd;
            bin_in  = dab_bin;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEP_COUNT - 1)) begin
               state_in = BK_LOCATE;
            end
         end
         BK_LOCATE: begin
            idx_in   = lead_idx;
            state_in = neg_ff ? BK_SIGN : BK_DIGITS;
         end
         BK_SIGN: begin
            if (out_free) begin
               out_load = 1'b1;
               char_in  = ASCII_MINUS;
               last_in  = 1'b0;
               state_in = BK_DIGITS;
            end
         end
         BK_DIGITS: begin
            if (out_free) begin
               out_load = 1'b1;
               char_in  = ASCII_ZERO + {3'b000, cur_digit};
               last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = BK_IDLE;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff  <= bcd_in;
      bin_ff  <= bin_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last_char  = last_ff;

endmodule

[rtl/signed_int_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII unit
// Turns each signed integer into its decimal text, one ASCII character per
// output transaction, most significant first, with the final one flagged.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                     Direction   Per transaction
//   req       req_valid, req_ready, req_value           in          one signed value
//   rsp       rsp_valid, rsp_ready, rsp_ascii_char,     out         one character
//             rsp_last_char
//
// A value passes through the front register and the queue, then the back end
// converts its magnitude to BCD, finds the leading digit and loads one
// character at a time into the output register; it takes no new value until
// the last character of the previous one is loaded. Reset is synchronous and
// clears only control. Stalls on either side are absorbed by the queue and
// the output register.
//
// The magnitude is formed as an unsigned value, so the most negative input
// converts exactly. A negative value gives a leading minus sign, zero gives
// the single character '0', and no terminator is sent.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [sitda_pkg::VALUE_BITS-1:0] req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [sitda_pkg::CHAR_BITS-1:0]         rsp_ascii_char,
   output logic                                    rsp_last_char
);
   import sitda_pkg::*;

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   // Front end: sign and magnitude of each accepted value.
   sitda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Short queue that decouples the two halves.
   sitda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Back end: BCD conversion and character output.
   sitda_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

   // Every character is a minus sign or a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char == ASCII_MINUS ||
                     (rsp_ascii_char >= ASCII_ZERO && rsp_ascii_char <= ASCII_NINE)))
      else $error("character outside the minus sign and digits");

   // The minus sign is never the final character of a number.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ascii_char == ASCII_MINUS) |-> !rsp_last_char)
      else $error("minus sign flagged as last character");

   // A taken minus sign is followed by a digit, never another sign.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_ascii_char == ASCII_MINUS) |=>
      !(rsp_valid && rsp_ascii_char == ASCII_MINUS))
      else $error("two minus signs in a row");

endmodule
